FILE: rtl/itod_pkg.sv
`default_nettype none

package itod_pkg;

	localparam int VAL_W   = 64;
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 7;
	localparam int PFX_W   = 2;
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(VAL_W);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_BIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_OCT   = RADIX_W'(8);
	localparam logic [RADIX_W-1:0] RADIX_HEX   = RADIX_W'(16);

	localparam logic [0:0] REG_RADIX     = 1'd0;
	localparam logic [0:0] REG_INDICATOR = 1'd1;

	localparam logic [PFX_W-1:0] PFX_NONE = 2'd0;
	localparam logic [PFX_W-1:0] PFX_BIN  = 2'd1;
	localparam logic [PFX_W-1:0] PFX_OCT  = 2'd2;
	localparam logic [PFX_W-1:0] PFX_HEX  = 2'd3;

	localparam logic [CHAR_W-1:0] ASCII_ZERO   = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_A_BASE = CHAR_W'(55);
	localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic start;
		logic fresh;
	} div_cmd_t;

	typedef struct packed {
		logic               done;
		logic               quo_zero;
		logic [RADIX_W-1:0] rem;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
		if (d < DEC_DIGITS)
			return ASCII_ZERO + CHAR_W'(d);
		return ASCII_A_BASE + CHAR_W'(d);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/itod_if.sv
`default_nettype none

interface itod_in_if;
	logic                         valid;
	logic                         ready;
	logic [itod_pkg::VAL_W-1:0]   value;
	logic                         is_signed;

	modport source (output valid, output value, output is_signed, input ready);
	modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface itod_out_if;
	logic                          valid;
	logic                          ready;
	logic [itod_pkg::CHAR_W-1:0]   digit_char;
	logic                          negative;
	logic [itod_pkg::PFX_W-1:0]    prefix_code;
	logic                          last;

	modport source (output valid, output digit_char, output negative, output prefix_code,
		output last, input ready);
	modport sink   (input valid, input digit_char, input negative, input prefix_code,
		input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/itod_div.sv
`default_nettype none

module itod_div (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire itod_pkg::div_cmd_t        cmd,
	input  wire [itod_pkg::VAL_W-1:0]      dividend,
	input  wire [itod_pkg::RADIX_W-1:0]    divisor,
	output itod_pkg::div_res_t             res
);
	import itod_pkg::*;

	logic [VAL_W-1:0]   quo_q;
	logic [RADIX_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	logic [RADIX_W:0]   trial;
	logic [RADIX_W:0]   diff;
	logic               ge;

	// One restoring step per cycle: the dividend shifts out at the top while
	// quotient bits shift in at the bottom of the same register.
	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VAL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			if (cmd.fresh)
				quo_q <= dividend;
		end else if (run_q) begin
			quo_q <= {quo_q[VAL_W-2:0], ge};
			rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign res.done     = done_q;
	assign res.quo_zero = (quo_q == '0);
	assign res.rem      = rem_q;

endmodule

`default_nettype wire

FILE: rtl/itod_stack.sv
`default_nettype none

module itod_stack (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire [itod_pkg::ADDR_W-1:0]    wr_addr,
	input  wire [itod_pkg::CHAR_W-1:0]    wr_data,
	input  wire                           rd_en,
	input  wire [itod_pkg::ADDR_W-1:0]    rd_addr,
	output logic [itod_pkg::CHAR_W-1:0]   rd_data
);
	import itod_pkg::*;

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/integer_to_radix_digits_core.sv
`default_nettype none

// Converts a 64-bit value, unsigned or two's complement, into ASCII digits in
// radix 2 to 36 (radix register values outside that range clamp to it), most
// significant digit first, one output transaction per digit with the sign flag,
// prefix code and a last marker. Each digit comes from a bit-serial divider that
// retires one quotient bit per cycle; the digits are stacked in a 64-entry
// memory and then emitted in reverse order, each one read from the stack and
// then loaded into the output register. A new value is accepted only after the
// previous one has been fully converted and its final digit is in the output
// register.
module integer_to_radix_digits_core (
	input  wire                            clk,
	input  wire                            arst_n,
	itod_in_if.sink                        in_ch,
	itod_out_if.source                     out_ch,
	input  wire                            cfg_we,
	input  wire [0:0]                      cfg_index,
	input  wire [itod_pkg::RADIX_W-1:0]    cfg_data
);
	import itod_pkg::*;

	state_t state_q, state_d;

	logic [RADIX_W-1:0] radix_q;
	logic               ind_q;

	logic [RADIX_W-1:0] r_q;
	logic               neg_q;
	logic [PFX_W-1:0]   pfx_q;
	logic [ADDR_W-1:0]  wr_ptr_q;
	logic [ADDR_W-1:0]  rd_ptr_q;

	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_neg_q;
	logic [PFX_W-1:0]   out_pfx_q;
	logic               out_last_q;

	logic               accept;
	logic               in_rdy;
	logic               wr_en;
	logic               rd_en;
	logic               out_load;
	div_cmd_t           div_cmd;
	div_res_t           div_res;

	logic [RADIX_W-1:0] eff_radix;
	logic [PFX_W-1:0]   pfx_new;
	logic               neg_new;
	logic [VAL_W-1:0]   mag;
	logic [CHAR_W-1:0]  rd_data;

	always_comb begin
		if (radix_q < RADIX_MIN)
			eff_radix = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			eff_radix = RADIX_MAX;
		else
			eff_radix = radix_q;
	end

	always_comb begin
		pfx_new = PFX_NONE;
		if (ind_q) begin
			if (eff_radix == RADIX_BIN)
				pfx_new = PFX_BIN;
			else if (eff_radix == RADIX_OCT)
				pfx_new = PFX_OCT;
			else if (eff_radix == RADIX_HEX)
				pfx_new = PFX_HEX;
		end
	end

	assign neg_new = in_ch.is_signed & in_ch.value[VAL_W-1];
	assign mag     = neg_new ? (~in_ch.value + VAL_W'(1)) : in_ch.value;

	assign in_ch.ready = in_rdy;
	assign accept      = in_ch.valid & in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			ind_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX:     radix_q <= cfg_data;
				REG_INDICATOR: ind_q   <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		in_rdy      = 1'b0;
		div_cmd     = '0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (in_ch.valid) begin
					div_cmd.start = 1'b1;
					div_cmd.fresh = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					wr_en = 1'b1;
					if (div_res.quo_zero)
						state_d = ST_EMIT_RD;
					else
						div_cmd.start = 1'b1;
				end
			end
			ST_EMIT_RD: begin
				// The read is issued only when the output register will be free
				// in the next cycle.
				if (!out_valid_q || out_ch.ready) begin
					rd_en   = 1'b1;
					state_d = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				out_load = 1'b1;
				state_d  = (rd_ptr_q == '0) ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_q      <= eff_radix;
			neg_q    <= neg_new;
			pfx_q    <= pfx_new;
			wr_ptr_q <= '0;
		end else if (wr_en) begin
			if (div_res.quo_zero)
				rd_ptr_q <= wr_ptr_q;
			else
				wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
		end else if (out_load) begin
			rd_ptr_q <= rd_ptr_q - ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= rd_data;
			out_neg_q  <= neg_q;
			out_pfx_q  <= pfx_q;
			out_last_q <= (rd_ptr_q == '0);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.digit_char  = out_char_q;
	assign out_ch.negative    = out_neg_q;
	assign out_ch.prefix_code = out_pfx_q;
	assign out_ch.last        = out_last_q;

	itod_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (mag),
		.divisor  (r_q),
		.res      (div_res)
	);

	itod_stack u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_ptr_q),
		.wr_data (ascii_of(div_res.rem)),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// A finished division is only expected while a number is being converted.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside the conversion phase");

	// Loading a digit must never overwrite one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> !out_valid_q || $past(out_ch.ready))
		else $error("output register loaded while still holding a digit");

	// The digit read from the bottom of the stack is the last of the number.
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD && rd_ptr_q == '0) |=> out_valid_q && out_last_q)
		else $error("final digit not marked as last");

	// An accepted value always starts a division in the following cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DIV && !div_res.done)
		else $error("accepted value did not start a division");

endmodule

`default_nettype wire

FILE: tb/sv/integer_to_radix_digits_core_test.sv
`default_nettype none

module integer_to_radix_digits_core_test;
	import itod_pkg::*;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             is_signed;
		bit               drain_first;
	} number_t;

	typedef struct {
		logic [CHAR_W-1:0] digit_char;
		logic              negative;
		logic [PFX_W-1:0]  prefix_code;
		logic              last;
	} digit_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [RADIX_W-1:0] cfg_data;

	itod_in_if  in_ch();
	itod_out_if out_ch();

	integer_to_radix_digits_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	number_t            pending_numbers[$];
	digit_t             expected_digits[$];
	logic [RADIX_W-1:0] radix_setting;
	logic               prefix_enable;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 mismatches;
	bit                 number_taken;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("integer_to_radix_digits_core_test: FAIL");
		$finish;
	end

	// Expands one accepted number into its digits, most significant first.
	function automatic void expand_digits(logic [VAL_W-1:0] raw, logic as_signed);
		logic               neg;
		logic [VAL_W-1:0]   mag;
		logic [RADIX_W-1:0] base;
		logic [RADIX_W-1:0] d;
		logic [PFX_W-1:0]   pfx;
		logic [CHAR_W-1:0]  rev [DEPTH];
		digit_t             dig;
		int                 n;
		neg = as_signed && raw[VAL_W-1];
		mag = neg ? ~raw + 1'b1 : raw;
		if (radix_setting < RADIX_MIN)
			base = RADIX_MIN;
		else if (radix_setting > RADIX_MAX)
			base = RADIX_MAX;
		else
			base = radix_setting;
		pfx = PFX_NONE;
		if (prefix_enable) begin
			case (base)
				RADIX_BIN: pfx = PFX_BIN;
				RADIX_OCT: pfx = PFX_OCT;
				RADIX_HEX: pfx = PFX_HEX;
				default:   pfx = PFX_NONE;
			endcase
		end
		n = 0;
		if (mag == '0) begin
			rev[0] = CHAR_W'("0");
			n = 1;
		end else begin
			while (mag != '0) begin
				d = RADIX_W'(mag % base);
				rev[n] = (d < DEC_DIGITS) ? CHAR_W'("0" + d) : CHAR_W'("A" + d - DEC_DIGITS);
				mag = mag / base;
				n++;
			end
		end
		for (int k = n - 1; k >= 0; k--) begin
			dig.digit_char  = rev[k];
			dig.negative    = neg;
			dig.prefix_code = pfx;
			dig.last        = (k == 0);
			expected_digits.insert(expected_digits.size(), dig);
		end
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic number_t random_number();
		number_t num;
		num.is_signed   = 1'($urandom_range(1));
		num.drain_first = 1'b0;
		case ($urandom_range(9))
			0: num.value = '0;
			1: num.value = '1;
			2: num.value = {1'b1, {(VAL_W-1){1'b0}}};
			3: num.value = VAL_W'($urandom_range(40));
			4: begin
				num.value = -VAL_W'($urandom_range(1000));
				num.is_signed = 1'b1;
			end
			// Shifting a random word by a random amount spreads the digit counts.
			default: num.value = {$urandom, $urandom} >> $urandom_range(VAL_W - 1);
		endcase
		return num;
	endfunction

	task automatic add_number(logic [VAL_W-1:0] value, logic is_signed);
		number_t num;
		num.value       = value;
		num.is_signed   = is_signed;
		num.drain_first = 1'b0;
		pending_numbers.insert(pending_numbers.size(), num);
	endtask

	task automatic write_reg(logic [0:0] index, logic [RADIX_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == REG_RADIX)
			radix_setting = data;
		else
			prefix_enable = data[0];
	endtask

	task automatic set_config(logic [RADIX_W-1:0] radix, logic indicator);
		write_reg(REG_RADIX, radix);
		write_reg(REG_INDICATOR, {{(RADIX_W-1){1'b0}}, indicator});
	endtask

	// Waits until every queued number went in and every digit came out. The check
	// runs at the rising edge, where the driver's updates have settled.
	task automatic wait_quiet();
		while (pending_numbers.size() != 0 || in_ch.valid || expected_digits.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		number_t next_number;
		if (arst_n && (!in_ch.valid || number_taken)) begin
			number_taken = 1'b0;
			if (pending_numbers.size() != 0
					&& !(pending_numbers[0].drain_first && expected_digits.size() != 0)
					&& $urandom_range(99) >= send_idle_pct) begin
				next_number = pending_numbers.pop_front();
				in_ch.value     <= next_number.value;
				in_ch.is_signed <= next_number.is_signed;
				in_ch.valid     <= 1'b1;
			end else begin
				in_ch.valid     <= 1'b0;
				in_ch.value     <= {$urandom, $urandom};
				in_ch.is_signed <= 1'($urandom_range(1));
			end
		end
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		digit_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expand_digits(in_ch.value, in_ch.is_signed);
				number_taken = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_digits.size() == 0) begin
					report_mismatch($sformatf("digit %0h with no number pending",
						out_ch.digit_char));
				end else begin
					want = expected_digits.pop_front();
					if (out_ch.digit_char !== want.digit_char)
						report_mismatch($sformatf("digit_char got %0h expected %0h",
							out_ch.digit_char, want.digit_char));
					if (out_ch.negative !== want.negative)
						report_mismatch($sformatf("negative got %0b expected %0b",
							out_ch.negative, want.negative));
					if (out_ch.prefix_code !== want.prefix_code)
						report_mismatch($sformatf("prefix_code got %0d expected %0d",
							out_ch.prefix_code, want.prefix_code));
					if (out_ch.last !== want.last)
						report_mismatch($sformatf("last got %0b expected %0b",
							out_ch.last, want.last));
				end
			end
		end
	end

	initial begin
		number_t num;
		int probe_radix [9] = '{2, 8, 16, 10, 0, 1, 37, 63, 36};
		int probe_prefix [9] = '{1, 1, 1, 1, 1, 0, 1, 0, 1};
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_RADIX;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.value     = '0;
		in_ch.is_signed = 1'b0;
		out_ch.ready    = 1'b0;
		radix_setting   = RADIX_RESET;
		prefix_enable   = 1'b0;
		mismatches      = 0;
		number_taken    = 1'b0;
		send_idle_pct   = 18;
		recv_idle_pct   = 49;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Decimal after reset: zero, one, the all-ones word both ways and the sign boundary.
		add_number('0, 1'b0);
		add_number('0, 1'b1);
		add_number(64'd1, 1'b0);
		add_number('1, 1'b1);
		add_number('1, 1'b0);
		add_number({1'b1, {(VAL_W-1){1'b0}}}, 1'b0);
		add_number({1'b0, {(VAL_W-1){1'b1}}}, 1'b1);

		// Prefix bases, clamping of out-of-range radix values and the top digit.
		for (int i = 0; i < 9; i++) begin
			wait_quiet();
			set_config(RADIX_W'(probe_radix[i]), 1'(probe_prefix[i]));
			add_number({1'b1, {(VAL_W-1){1'b0}}}, 1'b1);
			add_number('1, 1'b0);
			if (probe_radix[i] == 36)
				add_number(64'd35, 1'b0);
		end

		for (int phase = 0; phase < 7; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 49;
				recv_idle_pct = 18;
			end else if (phase == 5) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_quiet();
			if (phase == 0)
				set_config(RADIX_BIN, 1'b1);
			else
				set_config(RADIX_W'($urandom_range(63)), 1'($urandom_range(1)));
			for (int i = 0; i < 16; i++) begin
				num = random_number();
				num.drain_first = (i == 10) || ($urandom_range(24) == 0);
				pending_numbers.insert(pending_numbers.size(), num);
			end
		end

		wait_quiet();
		repeat (4400) @(posedge clk);
		if (mismatches == 0)
			$display("integer_to_radix_digits_core_test: PASS");
		else
			$display("integer_to_radix_digits_core_test: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
